FILE: rtl/audio_feedback_rate_controller_defines.svh
// Assertion macros for the feedback rate controller.
`ifndef AUDIO_FEEDBACK_RATE_CONTROLLER_DEFINES_SVH
`define AUDIO_FEEDBACK_RATE_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define AFRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afrc: implication check failed");
`define AFRC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afrc: next-cycle check failed");
`else
`define AFRC_ASSERT_IMP(label, ante, cons)
`define AFRC_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: rtl/afrc_pkg.sv
`default_nettype none

package afrc_pkg;

    localparam int BUFFER_SIZE_DEFAULT = 16384;
    localparam int RATE_LOG2_DEFAULT   = 2;

    localparam int CMD_W    = 3;
    localparam int SIZE_W   = 10;
    localparam int POS_W    = 14;
    localparam int ALT_W    = 8;
    localparam int FB_W     = 24;
    localparam int MARGIN_W = 13;
    localparam int FC_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_PACKET     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SOF        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FB_SENT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INCOMPLETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_ALT    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd1;

    localparam logic [FB_W-1:0]     NOMINAL_RESET = 24'hC0000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 13'd2000;
    localparam logic [FB_W-1:0]     FB_NUDGE      = 24'd256;
    localparam int                  FB_SCALE_SHIFT = 4;
    localparam logic [ALT_W-1:0]    ALT_MAX       = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SIZE_W-1:0] packet_size;
        logic [POS_W-1:0]  dma_position;
        logic              frame_parity;
        logic [ALT_W-1:0]  alt_value;
    } item_t;

    typedef struct packed {
        logic              send_feedback;
        logic [FB_W-1:0]   feedback_word;
        logic              start_playback;
        logic [POS_W-1:0]  write_position;
        logic              flush_sync;
        logic              request_error;
    } result_t;

    typedef struct packed {
        logic [FB_W-1:0] feedback;
        logic            speed_up;
        logic            slow_down;
    } meas_t;

endpackage

`default_nettype wire

FILE: rtl/afrc_measure.sv
`default_nettype none

module afrc_measure
    import afrc_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT,
    parameter int RATE_LOG2   = RATE_LOG2_DEFAULT
)
(
    input  wire logic [$clog2(BUFFER_SIZE)-1:0] dma,
    input  wire logic [$clog2(BUFFER_SIZE)-1:0] last_read,
    input  wire logic [$clog2(BUFFER_SIZE)-1:0] write_pointer,
    input  wire logic [MARGIN_W-1:0]            margin,
    input  wire logic                           speed_up,
    input  wire logic                           slow_down,
    output meas_t                               meas
);

    localparam int PW       = $clog2(BUFFER_SIZE);
    localparam int DW       = PW + 1;
    localparam int CMP_W    = PW + 3;
    localparam int FB_SHIFT = 8 - RATE_LOG2;
    localparam logic [DW-1:0] BUF_END = DW'(BUFFER_SIZE);
    localparam logic signed [CMP_W-1:0] HALF_S = CMP_W'(BUFFER_SIZE / 2);

    logic [DW-1:0]           delta;
    logic [DW-1:0]           diff;
    logic [FB_W-1:0]         fb_base;
    logic [FB_W-1:0]         fb_adj;
    logic signed [CMP_W-1:0] diff_s;
    logic signed [CMP_W-1:0] margin_s;
    logic signed [CMP_W-1:0] lo_s;
    logic signed [CMP_W-1:0] hi_s;
    logic                    su;
    logic                    sd;

    always_comb
    begin
        if (dma > last_read)
        begin
            delta = DW'(dma) - DW'(last_read);
        end
        else
        begin
            delta = BUF_END - DW'(last_read) + DW'(dma);
        end
        fb_base = FB_W'(delta) << FB_SHIFT;

        if (dma < write_pointer)
        begin
            diff = DW'(write_pointer) - DW'(dma);
        end
        else
        begin
            diff = BUF_END - DW'(dma) + DW'(write_pointer);
        end

        diff_s   = signed'(CMP_W'(diff));
        margin_s = signed'(CMP_W'(margin));
        lo_s     = HALF_S - margin_s;
        hi_s     = HALF_S + margin_s;

        su = (diff_s < lo_s) || ((diff_s < HALF_S) && speed_up);
        sd = (diff_s > hi_s) || ((diff_s > HALF_S) && slow_down);

        if (su)
        begin
            fb_adj = fb_base + FB_NUDGE;
        end
        else if (sd)
        begin
            fb_adj = fb_base - FB_NUDGE;
        end
        else
        begin
            fb_adj = fb_base;
        end

        meas.feedback  = fb_adj << FB_SCALE_SHIFT;
        meas.speed_up  = su;
        meas.slow_down = sd;
    end

endmodule

`default_nettype wire

FILE: rtl/afrc_core.sv
`default_nettype none

module afrc_core
    import afrc_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT,
    parameter int RATE_LOG2   = RATE_LOG2_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FB_W-1:0]      cfg_data,
    input  wire logic                 step,
    input  wire item_t                item,
    output result_t                   result
);

    localparam int PW   = $clog2(BUFFER_SIZE);
    localparam int DW   = PW + 1;
    localparam int MW   = PW + 2;
    localparam int SUBS = (2 ** POS_W - 1) / BUFFER_SIZE;
    localparam logic [DW-1:0] BUF_END  = DW'(BUFFER_SIZE);
    localparam logic [MW-1:0] BUF_MOD  = MW'(BUFFER_SIZE);
    localparam logic [PW-1:0] HALF_PTR = PW'(BUFFER_SIZE / 2);
    localparam logic [FC_W-1:0] FRAME_TARGET = FC_W'(1) << RATE_LOG2;

    function automatic logic [PW-1:0] wrap_dma(input logic [POS_W-1:0] pos);
        logic [MW-1:0] v;
        v = MW'(pos);
        for (int i = 0; i < SUBS; i++)
        begin
            if (v >= BUF_MOD)
            begin
                v = v - BUF_MOD;
            end
        end
        return PW'(v);
    endfunction

    logic [FB_W-1:0]     nominal_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic                active_reg, active_next;
    logic                playing_reg, playing_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [FB_W-1:0]     fb_reg, fb_next;
    logic [FC_W-1:0]     fc_reg, fc_next;
    logic [PW-1:0]       last_reg, last_next;
    logic                su_reg, su_next;
    logic                sd_reg, sd_next;
    logic                pend_reg, pend_next;
    logic                flight_reg, flight_next;
    logic                parity_reg, parity_next;

    logic [PW-1:0]   dma;
    logic [DW-1:0]   wp_sum;
    logic [FC_W-1:0] fc_inc;
    logic            want;
    logic            tx;
    logic            start;
    logic            flush;
    logic            err;
    meas_t           meas;

    assign dma = wrap_dma(item.dma_position);

    afrc_measure #(
        .BUFFER_SIZE (BUFFER_SIZE),
        .RATE_LOG2   (RATE_LOG2)
    ) u_measure (
        .dma           (dma),
        .last_read     (last_reg),
        .write_pointer (wp_reg),
        .margin        (margin_reg),
        .speed_up      (su_reg),
        .slow_down     (sd_reg),
        .meas          (meas)
    );

    always_comb
    begin
        active_next  = active_reg;
        playing_next = playing_reg;
        wp_next      = wp_reg;
        fb_next      = fb_reg;
        fc_next      = fc_reg;
        last_next    = last_reg;
        su_next      = su_reg;
        sd_next      = sd_reg;
        pend_next    = pend_reg;
        flight_next  = flight_reg;
        parity_next  = parity_reg;
        tx           = 1'b0;
        start        = 1'b0;
        flush        = 1'b0;
        err          = 1'b0;
        wp_sum       = DW'(wp_reg) + DW'(item.packet_size);
        fc_inc       = fc_reg + FC_W'(1);
        want         = (item.alt_value == ALT_MAX);

        case (item.command)
            CMD_PACKET:
            begin
                if (wp_sum >= BUF_END)
                begin
                    wp_next = PW'(wp_sum - BUF_END);
                end
                else
                begin
                    wp_next = PW'(wp_sum);
                end
                if (!playing_reg && (wp_next >= HALF_PTR))
                begin
                    playing_next = 1'b1;
                    flight_next  = 1'b0;
                    start        = 1'b1;
                end
            end
            CMD_SOF:
            begin
                if (active_reg)
                begin
                    fc_next = fc_inc;
                    if (fc_inc == FRAME_TARGET)
                    begin
                        fc_next = '0;
                        if (playing_reg)
                        begin
                            last_next = dma;
                            fb_next   = meas.feedback;
                            su_next   = meas.speed_up;
                            sd_next   = meas.slow_down;
                        end
                        pend_next = 1'b1;
                    end
                    if (!flight_reg && pend_next && (parity_reg == item.frame_parity))
                    begin
                        tx          = 1'b1;
                        flight_next = 1'b1;
                    end
                end
                else
                begin
                    last_next = dma;
                    fc_next   = '0;
                end
            end
            CMD_FB_SENT:
            begin
                flight_next = 1'b0;
                pend_next   = 1'b0;
                fc_next     = FC_W'(1);
            end
            CMD_INCOMPLETE:
            begin
                if (flight_reg && (parity_reg != item.frame_parity))
                begin
                    flight_next = 1'b0;
                    pend_next   = 1'b1;
                    parity_next = item.frame_parity;
                    flush       = 1'b1;
                end
            end
            CMD_SET_ALT:
            begin
                if (item.alt_value <= ALT_MAX)
                begin
                    if (want != active_reg)
                    begin
                        active_next = want;
                        fb_next     = nominal_reg;
                        if (!want)
                        begin
                            flight_next  = 1'b1;
                            playing_next = 1'b0;
                            wp_next      = '0;
                        end
                        else
                        begin
                            flight_next = 1'b0;
                            pend_next   = 1'b1;
                        end
                    end
                    flush = 1'b1;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        result.send_feedback  = tx;
        result.feedback_word  = fb_next;
        result.start_playback = start;
        result.write_position = POS_W'(wp_next);
        result.flush_sync     = flush;
        result.request_error  = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg <= NOMINAL_RESET;
            margin_reg  <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOMINAL: nominal_reg <= cfg_data;
                CFG_MARGIN:  margin_reg  <= cfg_data[MARGIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            playing_reg <= 1'b0;
            wp_reg      <= '0;
            fb_reg      <= NOMINAL_RESET;
            fc_reg      <= '0;
            last_reg    <= '0;
            su_reg      <= 1'b0;
            sd_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            flight_reg  <= 1'b1;
            parity_reg  <= 1'b0;
        end
        else if (step)
        begin
            active_reg  <= active_next;
            playing_reg <= playing_next;
            wp_reg      <= wp_next;
            fb_reg      <= fb_next;
            fc_reg      <= fc_next;
            last_reg    <= last_next;
            su_reg      <= su_next;
            sd_reg      <= sd_next;
            pend_reg    <= pend_next;
            flight_reg  <= flight_next;
            parity_reg  <= parity_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/audio_feedback_rate_controller.sv
`default_nettype none
`include "audio_feedback_rate_controller_defines.svh"

// Rate-feedback controller for an asynchronous USB audio sink. Each input
// transaction carries one event (packet received, start of frame, feedback
// sent, incomplete iso IN, set alternate setting) and yields exactly one
// result transaction with the event flags, the current 24-bit feedback word
// and the ring-buffer write position. One transaction is taken per cycle while item_stall is low.
// The edge that accepts an event loads the input register, and the next
// edge at which the result register is free loads its result. All event
// processing is done in the single logic stage between the two registers.
// The result register lets the next event enter while a result is
// stalled.
// Configuration writes (nominal feedback word, fill margin) take effect on
// the next event and must be made while no event is in flight.
module audio_feedback_rate_controller
    import afrc_pkg::*;
#(
    parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT,
    parameter int RATE_LOG2   = RATE_LOG2_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FB_W-1:0]      cfg_data,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result
);

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t core_result;
    logic    advance;
    logic [3:0] result_flags;

    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;

    afrc_core #(
        .BUFFER_SIZE (BUFFER_SIZE),
        .RATE_LOG2   (RATE_LOG2)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign result_flags = {result_reg.send_feedback, result_reg.start_playback,
                           result_reg.flush_sync, result_reg.request_error};

    `AFRC_ASSERT_IMP(a_stall_has_item, item_stall, item_valid_reg)
    `AFRC_ASSERT_IMP(a_empty_out_no_stall, !result_valid_reg, !item_stall)
    `AFRC_ASSERT_NXT(a_advance_fills_out, advance, result_valid_reg)
    `AFRC_ASSERT_IMP(a_single_event_flag, result_valid_reg, $onehot0(result_flags))

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import afrc_pkg::*;

    localparam int BUF_BYTES  = BUFFER_SIZE_DEFAULT;
    localparam int RATE_SHIFT = RATE_LOG2_DEFAULT;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    localparam int ALT_IDLE   = 0;
    localparam int ALT_STREAM = ALT_MAX;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FB_W-1:0]      cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;

    audio_feedback_rate_controller DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #1 clk = ~clk;

    // controller model state
    logic [FB_W-1:0]     cfg_nominal;
    logic [MARGIN_W-1:0] cfg_margin;
    logic                streaming;
    logic                is_playing;
    int                  wr_ptr;
    logic [31:0]         fb_val;
    logic [FC_W-1:0]     sof_count;
    int                  prev_read;
    logic                nudge_up;
    logic                nudge_down;
    logic                tx_pending;
    logic                tx_busy;
    logic                tx_parity;

    item_t   event_queue[$];
    result_t pending_status[$];

    int idle_level = 1;
    int hold_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int accepted_count = 0;
    int n_tx = 0;
    int n_start = 0;
    int n_measure = 0;
    int n_flush = 0;
    int n_reject = 0;

    function automatic void reset_controller_model();
        cfg_nominal = NOMINAL_RESET;
        cfg_margin  = MARGIN_RESET;
        streaming   = 1'b0;
        is_playing  = 1'b0;
        wr_ptr      = 0;
        fb_val      = 32'(NOMINAL_RESET);
        sof_count   = '0;
        prev_read   = 0;
        nudge_up    = 1'b0;
        nudge_down  = 1'b0;
        tx_pending  = 1'b0;
        tx_busy     = 1'b1;
        tx_parity   = 1'b0;
    endfunction

    function automatic result_t step_feedback_controller(input item_t ev);
        result_t r;
        int      dma;
        int      delta;
        int      diff;
        int      half;
        int      margin;
        logic    want;
        r      = '0;
        dma    = int'(ev.dma_position) % BUF_BYTES;
        half   = BUF_BYTES / 2;
        margin = int'(cfg_margin);
        case (ev.command)
            CMD_PACKET: begin
                wr_ptr = wr_ptr + int'(ev.packet_size);
                if (wr_ptr >= BUF_BYTES)
                    wr_ptr = wr_ptr - BUF_BYTES;
                if (!is_playing && wr_ptr >= half) begin
                    is_playing = 1'b1;
                    tx_busy = 1'b0;
                    r.start_playback = 1'b1;
                end
            end
            CMD_SOF: begin
                if (streaming) begin
                    sof_count = sof_count + 1'b1;
                    if (sof_count == FC_W'(1 << RATE_SHIFT)) begin
                        sof_count = '0;
                        if (is_playing) begin
                            delta = (dma > prev_read) ? dma - prev_read
                                                      : BUF_BYTES - prev_read + dma;
                            prev_read = dma;
                            fb_val = 32'(delta) << (8 - RATE_SHIFT);
                            diff = (dma < wr_ptr) ? wr_ptr - dma : BUF_BYTES - dma + wr_ptr;
                            nudge_up = (diff < half - margin) || (diff < half && nudge_up);
                            nudge_down = (diff > half + margin) || (diff > half && nudge_down);
                            if (nudge_up)
                                fb_val = fb_val + 32'(FB_NUDGE);
                            else if (nudge_down)
                                fb_val = fb_val - 32'(FB_NUDGE);
                            fb_val = fb_val << FB_SCALE_SHIFT;
                            tx_pending = 1'b1;
                            n_measure++;
                        end
                        else
                            tx_pending = 1'b1;
                    end
                    if (!tx_busy && tx_pending && tx_parity == ev.frame_parity) begin
                        r.send_feedback = 1'b1;
                        tx_busy = 1'b1;
                    end
                end
                else begin
                    prev_read = dma;
                    sof_count = '0;
                end
            end
            CMD_FB_SENT: begin
                tx_busy = 1'b0;
                tx_pending = 1'b0;
                sof_count = FC_W'(1);
            end
            CMD_INCOMPLETE: begin
                if (tx_busy && tx_parity != ev.frame_parity) begin
                    tx_busy = 1'b0;
                    tx_pending = 1'b1;
                    tx_parity = ev.frame_parity;
                    r.flush_sync = 1'b1;
                end
            end
            CMD_SET_ALT: begin
                if (ev.alt_value <= ALT_MAX) begin
                    want = (ev.alt_value == ALT_MAX);
                    if (want != streaming) begin
                        streaming = want;
                        fb_val = 32'(cfg_nominal);
                        if (!want) begin
                            tx_busy = 1'b1;
                            is_playing = 1'b0;
                            wr_ptr = 0;
                        end
                        else begin
                            tx_busy = 1'b0;
                            tx_pending = 1'b1;
                        end
                    end
                    r.flush_sync = 1'b1;
                end
                else
                    r.request_error = 1'b1;
            end
            default: ;
        endcase
        r.feedback_word  = fb_val[FB_W-1:0];
        r.write_position = wr_ptr[POS_W-1:0];
        n_tx      += r.send_feedback;
        n_start   += r.start_playback;
        n_flush   += r.flush_sync;
        n_reject  += r.request_error;
        return r;
    endfunction

    function automatic int pick_gap(input int level);
        int roll;
        if (level == 0)
            return 0;
        roll = $urandom_range(99);
        if (roll < ((level == 1) ? 65 : 35))
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string name, input longint unsigned exp,
                               input longint unsigned act);
        if (exp != act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                pending_status.push_back(step_feedback_controller(item));
                accepted_count++;
            end
            if (!item_valid || !item_stall) begin
                if (hold_left > 0) begin
                    hold_left--;
                    item_valid <= 1'b0;
                end
                else if (event_queue.size() > 0) begin
                    item <= event_queue.pop_front();
                    item_valid <= 1'b1;
                    hold_left = pick_gap(idle_level);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (pending_status.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    mismatches++;
                end
                else begin
                    want = pending_status.pop_front();
                    check_field("send_feedback", want.send_feedback, result.send_feedback);
                    check_field("feedback_word", want.feedback_word, result.feedback_word);
                    check_field("start_playback", want.start_playback, result.start_playback);
                    check_field("write_position", want.write_position, result.write_position);
                    check_field("flush_sync", want.flush_sync, result.flush_sync);
                    check_field("request_error", want.request_error, result.request_error);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= 1'b0;
                stall_left = pick_gap(idle_level);
            end
        end
    end

    task automatic queue_event(input logic [CMD_W-1:0] cmd, input int size, input int dma,
                               input int par, input int alt);
        item_t ev;
        ev.command      = cmd;
        ev.packet_size  = size[SIZE_W-1:0];
        ev.dma_position = dma[POS_W-1:0];
        ev.frame_parity = par[0];
        ev.alt_value    = alt[ALT_W-1:0];
        event_queue.push_back(ev);
    endtask

    task automatic queue_noise(input int count);
        item_t ev;
        repeat (count) begin
            ev.command      = CMD_W'($urandom_range(7));
            ev.packet_size  = SIZE_W'($urandom);
            ev.dma_position = POS_W'($urandom);
            ev.frame_parity = 1'($urandom);
            ev.alt_value    = ($urandom_range(3) == 0) ? ALT_W'($urandom_range(2))
                                                       : ALT_W'($urandom);
            event_queue.push_back(ev);
        end
    endtask

    // streaming session: alt on, then SOF/packet per frame with a drifting DMA reader
    task automatic queue_stream_session(input int frames);
        int written;
        int read_pos;
        int drift;
        int frame_no;
        int pkt;
        int size;
        written  = 0;
        read_pos = $urandom_range(BUF_BYTES - 1);
        drift    = $urandom_range(80) - 40;
        frame_no = $urandom_range(2047);
        pkt      = $urandom_range(150, 700);
        queue_event(CMD_SET_ALT, $urandom, $urandom, $urandom, ALT_STREAM);
        repeat (frames) begin
            frame_no++;
            queue_event(CMD_SOF, $urandom, read_pos, frame_no % 2, $urandom);
            size = pkt + $urandom_range(16) - 8;
            queue_event(CMD_PACKET, size, $urandom, $urandom, $urandom);
            written += size;
            if (written >= BUF_BYTES / 2)
                read_pos = (read_pos + pkt + drift + $urandom_range(16) - 8) % BUF_BYTES;
            if ($urandom_range(2) == 0)
                queue_event(CMD_FB_SENT, $urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(11) == 0)
                queue_event(CMD_INCOMPLETE, $urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(24) == 0)
                queue_noise(1);
        end
        if ($urandom_range(3) != 0)
            queue_event(CMD_SET_ALT, $urandom, $urandom, $urandom, ALT_IDLE);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        while (event_queue.size() > 0 || item_valid || pending_status.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [FB_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_NOMINAL)
            cfg_nominal = data;
        else if (idx == CFG_MARGIN)
            cfg_margin = data[MARGIN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        reset_controller_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        queue_event(CMD_RSVD5, 1023, 16383, 1, 255);
        queue_event(CMD_RSVD6, 0, 0, 0, 0);
        queue_event(CMD_RSVD7, 512, 8191, 1, 128);
        queue_event(CMD_SOF, 0, 16383, 1, 0);
        queue_event(CMD_INCOMPLETE, 0, 0, 1, 0);
        queue_event(CMD_INCOMPLETE, 0, 0, 1, 0);
        queue_event(CMD_FB_SENT, 0, 0, 0, 0);
        queue_event(CMD_SET_ALT, 0, 0, 0, 255);
        queue_event(CMD_SET_ALT, 0, 0, 0, 2);
        queue_event(CMD_SET_ALT, 0, 0, 0, ALT_IDLE);
        queue_event(CMD_PACKET, 0, 0, 0, 0);
        queue_event(CMD_SET_ALT, 0, 0, 0, ALT_STREAM);
        queue_event(CMD_SET_ALT, 0, 0, 0, ALT_STREAM);
        repeat (9)
            queue_event(CMD_PACKET, 1023, 0, 0, 0);
        queue_event(CMD_SOF, 0, 4000, 0, 0);
        queue_event(CMD_SOF, 0, 8000, 1, 0);
        queue_event(CMD_SOF, 0, 12000, 0, 0);
        queue_event(CMD_SOF, 0, 16383, 1, 0);
        queue_event(CMD_SET_ALT, 0, 0, 0, ALT_IDLE);
        wait_quiet();

        // largest nominal word, no hysteresis band
        idle_level = 2;
        write_register(CFG_NOMINAL, 24'hFFFFFF);
        write_register(CFG_MARGIN, 24'h000000);
        queue_stream_session(90);
        wait_quiet();

        // zero nominal, margin at its maximum just under half buffer, junk in the upper data bits
        idle_level = 1;
        write_register(CFG_NOMINAL, 24'h000000);
        write_register(CFG_MARGIN, {11'($urandom), 13'h1FFF});
        queue_stream_session(90);
        wait_quiet();

        // spare indexes must be ignored
        write_register(CFG_SPARE2, 24'($urandom));
        write_register(CFG_SPARE3, 24'($urandom));
        write_register(CFG_NOMINAL, 24'($urandom));
        write_register(CFG_MARGIN, 24'($urandom_range(100, 3000)));
        queue_stream_session(110);
        wait_quiet();
        idle_level = 0;
        queue_noise(150);
        wait_quiet();

        idle_level = 2;
        write_register(CFG_NOMINAL, NOMINAL_RESET);
        write_register(CFG_MARGIN, 24'(MARGIN_RESET));
        write_register(CFG_SPARE3, 24'hFFFFFF);
        queue_stream_session(110);
        wait_quiet();
        idle_level = 0;
        queue_stream_session(60);
        wait_quiet();

        $display("Ran %0d events over five register settings with stalls on both sides:",
                 accepted_count);
        $display("%0d feedback sends, %0d playback starts, %0d rate measurements, %0d flushes, %0d alt rejects",
                 n_tx, n_start, n_measure, n_flush, n_reject);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
